// ----- rtl/y2r_pkg.sv -----
// ----------------------------------------------------------------------------
// y2r_pkg: shared constants and types for the Y'CbCr to RGBA pixel core
// Holds the conversion coefficients, datapath widths and register indexes.
// ----------------------------------------------------------------------------
package y2r_pkg;

	// Number of colour channels: red, green, blue.
	localparam int NUM_CHAN = 3;
	localparam int CH_R = 0;
	localparam int CH_G = 1;
	localparam int CH_B = 2;

	// Configuration register indexes.
	localparam logic [1:0] REG_STUDIO_RANGE   = 2'd0;
	localparam logic [1:0] REG_CHROMA_PRESENT = 2'd1;
	localparam logic [1:0] REG_ALPHA_PRESENT  = 2'd2;

	// Chroma coefficients in units of 1/256.
	localparam int COEF_CR_R = 359;
	localparam int COEF_CB_G = 88;
	localparam int COEF_CR_G = 183;
	localparam int COEF_CB_B = 453;

	// Studio range: (v - 16) * 255 / 224, with 224 = 32 * 7.
	localparam int STUDIO_OFS   = 16;
	localparam int STUDIO_SHIFT = 5;
	// Reciprocal of 7 in 16 fractional bits, exact for dividends below 13107.
	localparam int RECIP7_W     = 14;
	localparam int RECIP7       = 9363;

	// Datapath widths.
	localparam int CHROMA_W = 9;   // centred chroma, signed
	localparam int PROD_W   = 17;  // chroma products, signed
	localparam int SUM_W    = 11;  // channel after luma add, signed
	localparam int SCALE_W  = 18;  // studio scaled value, signed
	localparam int QUOT_W   = 10;  // magnitude after division, unsigned

	typedef logic signed [CHROMA_W-1:0] chroma_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef logic signed [SCALE_W-1:0]  scale_t;
	typedef logic        [QUOT_W-1:0]   quot_t;
	typedef logic        [7:0]          byte_t;

endpackage

// ----- rtl/ycbcr_to_rgba_pixel_core.sv -----
// ----------------------------------------------------------------------------
// ycbcr_to_rgba_pixel_core: Y'CbCr plus alpha to RGBA pixel converter
// Five-stage pipeline: chroma products, luma add, range scaling, division
// by 224 in studio range and saturation to bytes.
// ----------------------------------------------------------------------------
// Usage
//   Input channel in_valid/in_ready carries one pixel per item: luma,
//   blue_diff, red_diff and alpha_in. Output channel out_valid/out_ready
//   carries red, green, blue and alpha_out for every input item, in order.
//   The configuration port (cfg_we, cfg_index, cfg_data) sets studio range,
//   chroma present and alpha present; write it only while the core is empty.
// Pipeline and throughput
//   An accepted item passes through the five stage registers in order and
//   is presented on the output from the stage 5 register. One item is
//   accepted in every cycle while out_ready is high; each stage is a single
//   register with its own valid bit.
// Reset and stalls
//   Reset empties the pipeline and loads studio range 0, chroma present 1
//   and alpha present 0. When the receiver holds out_ready low, the output
//   stage holds its item and stages behind it fill up; in_ready falls only
//   once every stage holds an item. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module ycbcr_to_rgba_pixel_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] luma,
	input  logic [7:0] blue_diff,
	input  logic [7:0] red_diff,
	input  logic [7:0] alpha_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic [7:0] alpha_out,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic       cfg_data
);

	localparam int NC = y2r_pkg::NUM_CHAN;

	// Configuration registers.
	logic studio_range_q;
	logic chroma_present_q;
	logic alpha_present_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			studio_range_q   <= 1'b0;
			chroma_present_q <= 1'b1;
			alpha_present_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				y2r_pkg::REG_STUDIO_RANGE:   studio_range_q   <= cfg_data;
				y2r_pkg::REG_CHROMA_PRESENT: chroma_present_q <= cfg_data;
				y2r_pkg::REG_ALPHA_PRESENT:  alpha_present_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage valid bits and advance enables.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	assign en_s5    = !v_s5 || out_ready;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// Stage 1: centre the chroma and form the three chroma products.
	y2r_pkg::chroma_t cb_c, cr_c;
	y2r_pkg::prod_t   prod_c [NC];

	always_comb begin
		if (chroma_present_q) begin
			cb_c = $signed({1'b0, blue_diff}) - y2r_pkg::chroma_t'(128);
			cr_c = $signed({1'b0, red_diff}) - y2r_pkg::chroma_t'(128);
		end else begin
			cb_c = '0;
			cr_c = '0;
		end
		prod_c[y2r_pkg::CH_R] = y2r_pkg::prod_t'(cr_c) *
			y2r_pkg::prod_t'(y2r_pkg::COEF_CR_R);
		prod_c[y2r_pkg::CH_G] = y2r_pkg::prod_t'(cb_c) *
			y2r_pkg::prod_t'(y2r_pkg::COEF_CB_G) +
			y2r_pkg::prod_t'(cr_c) * y2r_pkg::prod_t'(y2r_pkg::COEF_CR_G);
		prod_c[y2r_pkg::CH_B] = y2r_pkg::prod_t'(cb_c) *
			y2r_pkg::prod_t'(y2r_pkg::COEF_CB_B);
	end

	y2r_pkg::prod_t prod_s1 [NC];
	y2r_pkg::byte_t luma_s1, alpha_s1;
	logic           studio_s1;

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			prod_s1   <= prod_c;
			luma_s1   <= luma;
			alpha_s1  <= alpha_present_q ? alpha_in : 8'hFF;
			studio_s1 <= studio_range_q;
		end
	end

	// Stage 2: divide by 256 toward zero and add or subtract from luma.
	y2r_pkg::prod_t biased_c [NC];
	y2r_pkg::sum_t  quo_c    [NC];
	y2r_pkg::sum_t  sum_c    [NC];
	y2r_pkg::sum_t  luma_ext_c;

	always_comb begin
		luma_ext_c = y2r_pkg::sum_t'({1'b0, luma_s1});
		for (int i = 0; i < NC; i++) begin
			// Negative products are biased so that the shift truncates toward zero.
			biased_c[i] = prod_s1[i] +
				(prod_s1[i][y2r_pkg::PROD_W-1] ? y2r_pkg::prod_t'(255) : '0);
			quo_c[i] = y2r_pkg::sum_t'(biased_c[i] >>> 8);
		end
		sum_c[y2r_pkg::CH_R] = luma_ext_c + quo_c[y2r_pkg::CH_R];
		sum_c[y2r_pkg::CH_G] = luma_ext_c - quo_c[y2r_pkg::CH_G];
		sum_c[y2r_pkg::CH_B] = luma_ext_c + quo_c[y2r_pkg::CH_B];
	end

	y2r_pkg::sum_t  sum_s2 [NC];
	y2r_pkg::byte_t alpha_s2;
	logic           studio_s2;

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			sum_s2    <= sum_c;
			alpha_s2  <= alpha_s1;
			studio_s2 <= studio_s1;
		end
	end

	// Stage 3: studio range multiplies (v - 16) by 255; full range passes v.
	y2r_pkg::scale_t ofs_c   [NC];
	y2r_pkg::scale_t scale_c [NC];

	always_comb begin
		for (int i = 0; i < NC; i++) begin
			ofs_c[i] = y2r_pkg::scale_t'(sum_s2[i]) -
				y2r_pkg::scale_t'(y2r_pkg::STUDIO_OFS);
			if (studio_s2)
				scale_c[i] = (ofs_c[i] <<< 8) - ofs_c[i];
			else
				scale_c[i] = y2r_pkg::scale_t'(sum_s2[i]);
		end
	end

	y2r_pkg::scale_t scale_s3 [NC];
	y2r_pkg::byte_t  alpha_s3;
	logic            studio_s3;

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			scale_s3  <= scale_c;
			alpha_s3  <= alpha_s2;
			studio_s3 <= studio_s2;
		end
	end

	// Stage 4: magnitude, divided by 224 in studio range as a shift and a reciprocal of 7.
	localparam int MAG_W = y2r_pkg::SCALE_W - 1;
	localparam int DIV_W = MAG_W - y2r_pkg::STUDIO_SHIFT;
	localparam int MUL_W = DIV_W + y2r_pkg::RECIP7_W;

	logic [MAG_W-1:0]        mag_c  [NC];
	logic [DIV_W-1:0]        div_c  [NC];
	logic [MUL_W-1:0]        mul_c  [NC];
	y2r_pkg::quot_t          quot_c [NC];
	logic [NC-1:0]           neg_c;

	always_comb begin
		for (int i = 0; i < NC; i++) begin
			neg_c[i] = scale_s3[i][y2r_pkg::SCALE_W-1];
			mag_c[i] = neg_c[i] ? MAG_W'(-scale_s3[i]) : MAG_W'(scale_s3[i]);
			div_c[i] = mag_c[i][MAG_W-1:y2r_pkg::STUDIO_SHIFT];
			mul_c[i] = MUL_W'(div_c[i]) * MUL_W'(y2r_pkg::RECIP7);
			if (studio_s3)
				quot_c[i] = mul_c[i][16 +: y2r_pkg::QUOT_W];
			else
				quot_c[i] = mag_c[i][y2r_pkg::QUOT_W-1:0];
		end
	end

	y2r_pkg::quot_t quot_s4 [NC];
	logic [NC-1:0]  neg_s4;
	y2r_pkg::byte_t alpha_s4;

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			quot_s4  <= quot_c;
			neg_s4   <= neg_c;
			alpha_s4 <= alpha_s3;
		end
	end

	// Stage 5: saturate each channel to a byte into the output register.
	y2r_pkg::byte_t sat_c [NC];

	always_comb begin
		for (int i = 0; i < NC; i++) begin
			if (neg_s4[i])
				sat_c[i] = 8'h00;
			else if (quot_s4[i] > y2r_pkg::quot_t'(255))
				sat_c[i] = 8'hFF;
			else
				sat_c[i] = quot_s4[i][7:0];
		end
	end

	y2r_pkg::byte_t chan_s5 [NC];
	y2r_pkg::byte_t alpha_s5;

	always_ff @(posedge clk) begin
		if (en_s5 && v_s4) begin
			chan_s5  <= sat_c;
			alpha_s5 <= alpha_s4;
		end
	end

	assign out_valid = v_s5;
	assign red       = chan_s5[y2r_pkg::CH_R];
	assign green     = chan_s5[y2r_pkg::CH_G];
	assign blue      = chan_s5[y2r_pkg::CH_B];
	assign alpha_out = alpha_s5;

	// Any empty stage leaves room for a new item.
	a_ready_when_room: assert property (@(posedge clk) disable iff (!arst_n)
		!(v_s1 && v_s2 && v_s3 && v_s4 && v_s5) |-> in_ready)
		else $error("in_ready low while the pipeline has a free stage");

	// A full output stage that is not taken stalls everything behind it.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && !out_ready) |-> !in_ready)
		else $error("item accepted while the full pipeline is stalled");

	// A stalled middle stage keeps its item.
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !en_s4) |=> (v_s3 && $stable(scale_s3[y2r_pkg::CH_G])))
		else $error("stage 3 item changed while stalled");

	// With chroma absent every channel carries the same grey value.
	a_mono_grey: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && en_s2 && !chroma_present_q && !$past(chroma_present_q) &&
		 prod_s1[y2r_pkg::CH_R] == '0) |=>
		(sum_s2[y2r_pkg::CH_R] == sum_s2[y2r_pkg::CH_G] &&
		 sum_s2[y2r_pkg::CH_G] == sum_s2[y2r_pkg::CH_B]) ||
		(prod_s1[y2r_pkg::CH_G] != '0) || ($past(prod_s1[y2r_pkg::CH_B]) != '0))
		else $error("mono item produced unequal channels");

endmodule
